// ===== sv/qfrm_pkg.sv =====
`default_nettype none
package qfrm_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int FIELD_W    = 18;
    localparam int SUM_W      = FIELD_W + 2;
    localparam int RAD_W      = FIELD_W + 1;
    localparam int D_W        = FIELD_W + 1;
    localparam int X_W        = 2 * FIELD_W;
    localparam int ROOT_W     = FIELD_W;
    localparam int SQR_W      = ROOT_W + 3;
    localparam int Q_W        = FIELD_W + 1;
    localparam int DIVS_W     = ROOT_W + 1;
    localparam int REM_W      = X_W + 1;
    localparam int SQRT_STEPS = X_W / 2;
    localparam int DIV_STEPS  = Q_W;
    localparam int LANES      = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_DIAG0 = 2'd1;
    localparam logic [1:0] BR_DIAG1 = 2'd2;
    localparam logic [1:0] BR_DIAG2 = 2'd3;

    localparam logic [0:0] REG_INPUT_IS_AXES = 1'b0;

    localparam logic signed [FIELD_W-1:0] QMAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic signed [FIELD_W-1:0] QMIN = {1'b1, {(FIELD_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]                  branch;
        logic                        bad;
        logic [RAD_W-1:0]            rad;
        logic [LANES-1:0][D_W-1:0]   d;
    } qfrm_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qfrm_qstat_t;

endpackage
`default_nettype wire

// ===== sv/qfrm_in_if.sv =====
`default_nettype none
interface qfrm_in_if;
    import qfrm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  m_r0c0;
    logic signed [FIELD_W-1:0]  m_r0c1;
    logic signed [FIELD_W-1:0]  m_r0c2;
    logic signed [FIELD_W-1:0]  m_r1c0;
    logic signed [FIELD_W-1:0]  m_r1c1;
    logic signed [FIELD_W-1:0]  m_r1c2;
    logic signed [FIELD_W-1:0]  m_r2c0;
    logic signed [FIELD_W-1:0]  m_r2c1;
    logic signed [FIELD_W-1:0]  m_r2c2;

    modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                    m_r2c0, m_r2c1, m_r2c2, input ready);
    modport sink (input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                  m_r2c0, m_r2c1, m_r2c2, output ready);
endinterface
`default_nettype wire

// ===== sv/qfrm_out_if.sv =====
`default_nettype none
interface qfrm_out_if;
    import qfrm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  quat_w;
    logic signed [FIELD_W-1:0]  quat_x;
    logic signed [FIELD_W-1:0]  quat_y;
    logic signed [FIELD_W-1:0]  quat_z;
    logic [1:0]                 branch_taken;
    logic                       bad_radicand;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, branch_taken,
                    bad_radicand, input ready);
    modport sink (input valid, quat_w, quat_x, quat_y, quat_z, branch_taken,
                  bad_radicand, output ready);
endinterface
`default_nettype wire

// ===== sv/quaternion_from_rotation_matrix.sv =====
// Converts one 3x3 rotation matrix (nine signed Q2.16 elements) per transaction into a unit
// quaternion with saturated Q2.16 parts, the branch taken and a flag for a radicand that was
// not positive, in which case the four parts are zero. The block accepts one transaction per
// clock cycle while its queue is not full and delivers one result per cycle while the output
// is not stalled; each result passes an 18-step pipelined square root followed by a 19-step
// pipelined divider for the three off-diagonal parts. A four-entry queue between
// the classifying front end and the arithmetic pipeline absorbs output stalls. The only
// register, input_is_axes at address 0, selects the transposed reading of the inputs and
// should be written while no transaction is in flight.
`default_nettype none
module quaternion_from_rotation_matrix
    import qfrm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    qfrm_in_if.sink          mat,
    qfrm_out_if.source       quat
);

    logic        axes_reg;
    logic        push;
    logic        pop;
    qfrm_job_t   push_job;
    qfrm_job_t   pop_job;
    qfrm_qstat_t qstat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_INPUT_IS_AXES) ? {31'b0, axes_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axes_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_INPUT_IS_AXES))
        begin
            axes_reg <= pwdata[0];
        end
    end

    qfrm_front u_front (
        .mat           (mat),
        .input_is_axes (axes_reg),
        .qstat         (qstat),
        .push          (push),
        .job           (push_job)
    );

    qfrm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .qstat    (qstat)
    );

    qfrm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .qstat   (qstat),
        .pop_job (pop_job),
        .pop     (pop),
        .quat    (quat)
    );

endmodule
`default_nettype wire

// ===== sv/qfrm_front.sv =====
`default_nettype none
module qfrm_front
    import qfrm_pkg::*;
(
    qfrm_in_if.sink     mat,
    input  wire logic   input_is_axes,
    input  wire qfrm_qstat_t qstat,
    output logic        push,
    output qfrm_job_t   job
);

    localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) <<< FRAC_BITS;

    logic signed [SUM_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [SUM_W-1:0] trace;
    logic signed [SUM_W-1:0] rad;
    logic signed [SUM_W-1:0] d0, d1, d2;
    logic [1:0]              branch;

    assign mat.ready = !qstat.full;
    assign push      = mat.valid && !qstat.full;

    always_comb
    begin
        m00 = SUM_W'(mat.m_r0c0);
        m11 = SUM_W'(mat.m_r1c1);
        m22 = SUM_W'(mat.m_r2c2);
        if (input_is_axes)
        begin
            m01 = SUM_W'(mat.m_r1c0);
            m02 = SUM_W'(mat.m_r2c0);
            m10 = SUM_W'(mat.m_r0c1);
            m12 = SUM_W'(mat.m_r2c1);
            m20 = SUM_W'(mat.m_r0c2);
            m21 = SUM_W'(mat.m_r1c2);
        end
        else
        begin
            m01 = SUM_W'(mat.m_r0c1);
            m02 = SUM_W'(mat.m_r0c2);
            m10 = SUM_W'(mat.m_r1c0);
            m12 = SUM_W'(mat.m_r1c2);
            m20 = SUM_W'(mat.m_r2c0);
            m21 = SUM_W'(mat.m_r2c1);
        end
    end

    always_comb
    begin
        trace = m00 + m11 + m22;
        if (trace > 0)
        begin
            branch = BR_TRACE;
        end
        else if (m22 > ((m11 > m00) ? m11 : m00))
        begin
            branch = BR_DIAG2;
        end
        else if (m11 > m00)
        begin
            branch = BR_DIAG1;
        end
        else
        begin
            branch = BR_DIAG0;
        end
    end

    always_comb
    begin
        unique case (branch)
            BR_TRACE:
            begin
                rad = trace + ONE;
                d0  = m21 - m12;
                d1  = m02 - m20;
                d2  = m10 - m01;
            end
            BR_DIAG0:
            begin
                rad = m00 - m11 - m22 + ONE;
                d0  = m21 - m12;
                d1  = m10 + m01;
                d2  = m20 + m02;
            end
            BR_DIAG1:
            begin
                rad = m11 - m22 - m00 + ONE;
                d0  = m02 - m20;
                d1  = m01 + m10;
                d2  = m21 + m12;
            end
            default:
            begin
                rad = m22 - m00 - m11 + ONE;
                d0  = m10 - m01;
                d1  = m02 + m20;
                d2  = m12 + m21;
            end
        endcase
    end

    always_comb
    begin
        job.branch = branch;
        job.bad    = (rad <= 0);
        job.rad    = (rad <= 0) ? '0 : rad[RAD_W-1:0];
        job.d[0]   = d0[D_W-1:0];
        job.d[1]   = d1[D_W-1:0];
        job.d[2]   = d2[D_W-1:0];
    end

endmodule
`default_nettype wire

// ===== sv/qfrm_queue.sv =====
`default_nettype none
module qfrm_queue
    import qfrm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire qfrm_job_t   push_job,
    input  wire logic        pop,
    output qfrm_job_t        pop_job,
    output qfrm_qstat_t      qstat
);

    qfrm_job_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign qstat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_job     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// ===== sv/qfrm_back.sv =====
`default_nettype none
module qfrm_back
    import qfrm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire qfrm_qstat_t qstat,
    input  wire qfrm_job_t   pop_job,
    output logic             pop,
    qfrm_out_if.source       quat
);

    typedef struct packed {
        logic [1:0]                  branch;
        logic                        bad;
        logic [LANES-1:0][D_W-1:0]   d;
        logic [X_W-1:0]              x;
        logic [SQR_W-1:0]            rem;
        logic [ROOT_W-1:0]           root;
    } sq_t;

    typedef struct packed {
        logic [1:0]                  branch;
        logic                        bad;
        logic [ROOT_W-2:0]           big;
        logic [DIVS_W-1:0]           dvs;
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][REM_W-1:0] rem;
        logic [LANES-1:0][Q_W-1:0]   q;
    } dv_t;

    logic                    adv;
    logic [SQRT_STEPS:0]     sq_vld_reg;
    sq_t                     sq_reg  [SQRT_STEPS+1];
    sq_t                     sq_next [SQRT_STEPS+1];
    logic [DIV_STEPS:0]      dv_vld_reg;
    dv_t                     dv_reg  [DIV_STEPS+1];
    dv_t                     dv_next [DIV_STEPS+1];
    logic                    out_vld_reg;
    logic signed [FIELD_W-1:0] w_reg, x_reg, y_reg, z_reg;
    logic [1:0]              br_reg;
    logic                    bad_reg;
    logic signed [FIELD_W-1:0] w_next, x_next, y_next, z_next;
    logic signed [FIELD_W-1:0] lane0, lane1, lane2, bigv;

    function automatic sq_t sqrt_step(input sq_t a);
        sq_t               r;
        logic [SQR_W-1:0]  r2;
        logic [SQR_W-1:0]  t;
        r    = a;
        r2   = {a.rem[SQR_W-3:0], a.x[X_W-1 -: 2]};
        t    = SQR_W'({a.root, 2'b01});
        r.x  = a.x << 2;
        if (r2 >= t)
        begin
            r.rem  = r2 - t;
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = r2;
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic dv_t div_init(input sq_t a);
        dv_t              r;
        logic [D_W-1:0]   mag;
        r.branch = a.branch;
        r.bad    = a.bad;
        r.big    = a.root[ROOT_W-1:1];
        r.dvs    = {a.root, 1'b0};
        r.q      = '0;
        for (int l = 0; l < LANES; l++)
        begin
            r.neg[l] = a.d[l][D_W-1];
            mag      = a.d[l][D_W-1] ? D_W'(-a.d[l]) : a.d[l];
            r.rem[l] = (REM_W'(mag) << FRAC_BITS) + REM_W'(a.root);
        end
        return r;
    endfunction

    function automatic dv_t div_step(input dv_t a, input int b);
        dv_t              r;
        logic [REM_W-1:0] t;
        r = a;
        t = REM_W'(a.dvs) << b;
        for (int l = 0; l < LANES; l++)
        begin
            if (a.rem[l] >= t)
            begin
                r.rem[l]  = a.rem[l] - t;
                r.q[l][b] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic signed [FIELD_W-1:0] sat_lane(input logic neg,
                                                           input logic [Q_W-1:0] q);
        logic [Q_W-1:0] qv;
        qv = q[Q_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : q;
        if (neg)
        begin
            return (qv >= Q_W'(2**(FIELD_W-1))) ? QMIN : FIELD_W'(-qv);
        end
        return (qv > Q_W'(QMAX)) ? QMAX : qv[FIELD_W-1:0];
    endfunction

    assign adv = !out_vld_reg || quat.ready;
    assign pop = adv && !qstat.empty;

    always_comb
    begin
        sq_next[0].branch = pop_job.branch;
        sq_next[0].bad    = pop_job.bad;
        sq_next[0].d      = pop_job.d;
        sq_next[0].x      = X_W'(pop_job.rad) << FRAC_BITS;
        sq_next[0].rem    = '0;
        sq_next[0].root   = '0;
        for (int n = 0; n < SQRT_STEPS; n++)
        begin
            sq_next[n+1] = sqrt_step(sq_reg[n]);
        end
        dv_next[0] = div_init(sq_reg[SQRT_STEPS]);
        for (int n = 0; n < DIV_STEPS; n++)
        begin
            dv_next[n+1] = div_step(dv_reg[n], DIV_STEPS - 1 - n);
        end
    end

    always_comb
    begin
        lane0 = sat_lane(dv_reg[DIV_STEPS].neg[0], dv_reg[DIV_STEPS].q[0]);
        lane1 = sat_lane(dv_reg[DIV_STEPS].neg[1], dv_reg[DIV_STEPS].q[1]);
        lane2 = sat_lane(dv_reg[DIV_STEPS].neg[2], dv_reg[DIV_STEPS].q[2]);
        bigv  = FIELD_W'(dv_reg[DIV_STEPS].big);
        unique case (dv_reg[DIV_STEPS].branch)
            BR_TRACE:
            begin
                w_next = bigv;  x_next = lane0; y_next = lane1; z_next = lane2;
            end
            BR_DIAG0:
            begin
                w_next = lane0; x_next = bigv;  y_next = lane1; z_next = lane2;
            end
            BR_DIAG1:
            begin
                w_next = lane0; x_next = lane1; y_next = bigv;  z_next = lane2;
            end
            default:
            begin
                w_next = lane0; x_next = lane1; y_next = lane2; z_next = bigv;
            end
        endcase
        if (dv_reg[DIV_STEPS].bad)
        begin
            w_next = '0; x_next = '0; y_next = '0; z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg  <= '0;
            dv_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_vld_reg  <= {sq_vld_reg[SQRT_STEPS-1:0], pop};
            dv_vld_reg  <= {dv_vld_reg[DIV_STEPS-1:0], sq_vld_reg[SQRT_STEPS]};
            out_vld_reg <= dv_vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int n = 0; n <= SQRT_STEPS; n++)
            begin
                sq_reg[n] <= sq_next[n];
            end
            for (int n = 0; n <= DIV_STEPS; n++)
            begin
                dv_reg[n] <= dv_next[n];
            end
            w_reg   <= w_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            br_reg  <= dv_reg[DIV_STEPS].branch;
            bad_reg <= dv_reg[DIV_STEPS].bad;
        end
    end

    assign quat.valid        = out_vld_reg;
    assign quat.quat_w       = w_reg;
    assign quat.quat_x       = x_reg;
    assign quat.quat_y       = y_reg;
    assign quat.quat_z       = z_reg;
    assign quat.branch_taken = br_reg;
    assign quat.bad_radicand = bad_reg;

endmodule
`default_nettype wire

// ===== sv/qfrm_checker.sv =====
`default_nettype none
module qfrm_checker
    import qfrm_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic signed [FIELD_W-1:0] qw,
    input wire logic signed [FIELD_W-1:0] qx,
    input wire logic signed [FIELD_W-1:0] qy,
    input wire logic signed [FIELD_W-1:0] qz,
    input wire logic [1:0]                branch,
    input wire logic                      bad
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(qw) && $stable(branch))
        else $error("Stalled result transaction changed.");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad |-> qw == 0 && qx == 0 && qy == 0 && qz == 0)
        else $error("Bad radicand with nonzero quaternion.");

    a_trace_good: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && branch == BR_TRACE |-> !bad && !qw[FIELD_W-1])
        else $error("Trace branch gave a bad radicand or negative w.");

    a_big_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && branch == BR_DIAG0 |-> !qx[FIELD_W-1])
        else $error("Selected component x is negative.");

endmodule

bind quaternion_from_rotation_matrix qfrm_checker u_qfrm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (quat.valid),
    .out_ready (quat.ready),
    .qw        (quat.quat_w),
    .qx        (quat.quat_x),
    .qy        (quat.quat_y),
    .qz        (quat.quat_z),
    .branch    (quat.branch_taken),
    .bad       (quat.bad_radicand)
);
`default_nettype wire

// ===== tb/qfrm_tb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface qfrm_cfg_bus;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
endinterface
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import qfrm_pkg::*;

    typedef logic signed [FIELD_W-1:0] fld_t;

    typedef struct packed {
        fld_t       w;
        fld_t       x;
        fld_t       y;
        fld_t       z;
        logic [1:0] branch;
        logic       bad;
    } quat_t;

    class quat_scoreboard;
        quat_t pending[$];
        int    mismatches = 0;
        bit    axes_mode = 0;

        function automatic longint isqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function automatic longint half_div(longint d, longint s);
            longint unsigned mag;
            longint unsigned q;
            mag = (d < 0 ? -d : d);
            mag = mag << FRAC_BITS;
            q = (mag + s) / (2 * s);
            if (q > 64'h40000)
                q = 64'h40000;
            return d < 0 ? -longint'(q) : longint'(q);
        endfunction

        function automatic fld_t clip(longint v);
            if (v > 131071)
                v = 131071;
            if (v < -131072)
                v = -131072;
            return fld_t'(v);
        endfunction

        function void note_matrix(fld_t e[9]);
            longint m[3][3];
            longint q[4];
            longint one;
            longint tr;
            longint rad;
            longint s;
            int i;
            int j;
            int k;
            quat_t res;
            one = 64'd1 << FRAC_BITS;
            q = '{0, 0, 0, 0};
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    if (axes_mode)
                        m[c][r] = e[r*3+c];
                    else
                        m[r][c] = e[r*3+c];
            res.bad = 0;
            tr = m[0][0] + m[1][1] + m[2][2];
            if (tr > 0)
            begin
                res.branch = BR_TRACE;
                rad = tr + one;
                s = isqrt(rad << FRAC_BITS);
                q[0] = isqrt(rad << (FRAC_BITS - 2));
                q[1] = half_div(m[2][1] - m[1][2], s);
                q[2] = half_div(m[0][2] - m[2][0], s);
                q[3] = half_div(m[1][0] - m[0][1], s);
            end
            else
            begin
                i = 0;
                if (m[1][1] > m[0][0])
                    i = 1;
                if (m[2][2] > m[i][i])
                    i = 2;
                j = (i + 1) % 3;
                k = (j + 1) % 3;
                res.branch = 2'(i + 1);
                rad = m[i][i] - m[j][j] - m[k][k] + one;
                if (rad <= 0)
                    res.bad = 1;
                else
                begin
                    s = isqrt(rad << FRAC_BITS);
                    q[1+i] = isqrt(rad << (FRAC_BITS - 2));
                    q[0] = half_div(m[k][j] - m[j][k], s);
                    q[1+j] = half_div(m[j][i] + m[i][j], s);
                    q[1+k] = half_div(m[k][i] + m[i][k], s);
                end
            end
            res.w = clip(q[0]);
            res.x = clip(q[1]);
            res.y = clip(q[2]);
            res.z = clip(q[3]);
            pending.push_back(res);
        endfunction

        function void check_quat(quat_t got);
            quat_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.w !== want.w || got.x !== want.x || got.y !== want.y
                || got.z !== want.z || got.branch !== want.branch || got.bad !== want.bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    qfrm_cfg_bus cfg();
    qfrm_in_if   mat();
    qfrm_out_if  quat();
    quat_scoreboard sb;
    int stall_mode;

    quaternion_from_rotation_matrix dut (
        .clk(clk), .rst_n(rst_n),
        .psel(cfg.psel), .penable(cfg.penable), .pwrite(cfg.pwrite),
        .paddr(cfg.paddr), .pwdata(cfg.pwdata), .prdata(cfg.prdata),
        .pready(cfg.pready), .mat(mat.sink), .quat(quat.source)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("quaternion_from_rotation_matrix regression: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && quat.valid && quat.ready)
            sb.check_quat('{quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z,
                            quat.branch_taken, quat.bad_radicand});
        case (stall_mode)
            0: quat.ready <= 1'b1;
            1: quat.ready <= ($urandom_range(0, 3) != 0);
            2: quat.ready <= ($urandom_range(0, 1) != 0);
            default: quat.ready <= ($urandom_range(0, 7) == 0);
        endcase
        if ($urandom_range(0, 99) == 0)
            stall_mode <= $urandom_range(0, 3);
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        cfg.psel <= 1;
        cfg.penable <= 0;
        cfg.pwrite <= 1;
        cfg.paddr <= addr;
        cfg.pwdata <= value;
        @(posedge clk);
        cfg.penable <= 1;
        @(posedge clk);
        while (!cfg.pready)
            @(posedge clk);
        cfg.psel <= 0;
        cfg.penable <= 0;
        cfg.pwrite <= 0;
        sb.axes_mode = value[0];
    endtask

    task automatic send_matrix(fld_t e[9], bit hold);
        mat.valid <= 1;
        {mat.m_r0c0, mat.m_r0c1, mat.m_r0c2, mat.m_r1c0, mat.m_r1c1, mat.m_r1c2,
         mat.m_r2c0, mat.m_r2c1, mat.m_r2c2} <= {e[0], e[1], e[2], e[3], e[4],
                                                 e[5], e[6], e[7], e[8]};
        @(posedge clk);
        while (!mat.ready)
            @(posedge clk);
        sb.note_matrix(e);
        if (!hold)
            mat.valid <= 0;
    endtask

    function automatic fld_t rand_fld();
        case ($urandom_range(0, 5))
            0: return 18'sh1FFFF;
            1: return 18'sh20000;
            2: return 18'sd0;
            3: return fld_t'($urandom_range(0, 131072)) - 18'sd65536;
            default: return fld_t'($urandom);
        endcase
    endfunction

    function automatic void rotation_like(output fld_t e[9]);
        int perm;
        fld_t sgn[3];
        perm = $urandom_range(0, 5);
        for (int a = 0; a < 9; a++)
            e[a] = fld_t'($urandom_range(0, 8192)) - 18'sd4096;
        for (int a = 0; a < 3; a++)
            sgn[a] = $urandom_range(0, 1) ? 18'sd60000 : -18'sd60000;
        case (perm)
            0: begin e[0] = sgn[0]; e[4] = sgn[1]; e[8] = sgn[2]; end
            1: begin e[0] = sgn[0]; e[5] = sgn[1]; e[7] = sgn[2]; end
            2: begin e[1] = sgn[0]; e[3] = sgn[1]; e[8] = sgn[2]; end
            3: begin e[1] = sgn[0]; e[5] = sgn[1]; e[6] = sgn[2]; end
            4: begin e[2] = sgn[0]; e[3] = sgn[1]; e[7] = sgn[2]; end
            default: begin e[2] = sgn[0]; e[4] = sgn[1]; e[6] = sgn[2]; end
        endcase
    endfunction

    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (60) @(posedge clk);
    endtask

    task automatic run_random(int count);
        fld_t e[9];
        int burst;
        int gap;
        int n;
        n = 0;
        while (n < count)
        begin
            burst = $urandom_range(1, 20);
            gap = $urandom_range(1, 6);
            for (int b = 0; b < burst && n < count; b++)
            begin
                if ($urandom_range(0, 3) != 0)
                    rotation_like(e);
                else
                    foreach (e[a])
                        e[a] = rand_fld();
                send_matrix(e, (b + 1 < burst) && (n + 1 < count));
                n++;
            end
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        fld_t e[9];
        sb = new();
        stall_mode = 0;
        rst_n = 0;
        cfg.psel = 0;
        cfg.penable = 0;
        cfg.pwrite = 0;
        cfg.paddr = '0;
        cfg.pwdata = '0;
        mat.valid = 0;
        {mat.m_r0c0, mat.m_r0c1, mat.m_r0c2, mat.m_r1c0, mat.m_r1c1, mat.m_r1c2,
         mat.m_r2c0, mat.m_r2c1, mat.m_r2c2} = '0;
        quat.ready = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        e = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536};
        send_matrix(e, 1);
        e = '{65536, 0, 0, 0, -65536, 0, 0, 0, -65536};
        send_matrix(e, 1);
        e = '{-65536, 0, 0, 0, 65536, 0, 0, 0, -65536};
        send_matrix(e, 1);
        e = '{-65536, 0, 0, 0, -65536, 0, 0, 0, 65536};
        send_matrix(e, 1);
        e = '{0, -65536, 0, 65536, 0, 0, 0, 0, 65536};
        send_matrix(e, 1);
        e = '{-131072, 0, 0, 0, 131071, 0, 0, 0, 131071};
        send_matrix(e, 1);
        e = '{131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071};
        send_matrix(e, 1);
        e = '{-131072, -131072, -131072, -131072, -131072, -131072, -131072,
              -131072, -131072};
        send_matrix(e, 1);
        e = '{0, 131071, -131072, -131072, -131072, 131071, 131071, -131072, 1};
        send_matrix(e, 1);
        e = '{-1, 131071, -131072, -131072, -131072, 131071, 131071, -131072, -1};
        send_matrix(e, 1);
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(e, 0);
        drain();

        write_reg(3'd0 + 3'(REG_INPUT_IS_AXES), 32'hFFFF_FFFF);
        e = '{0, -65536, 0, 65536, 0, 0, 0, 0, 65536};
        send_matrix(e, 1);
        e = '{-65536, 5000, -7000, 3000, 65536, 131071, 100, -131072, -65536};
        send_matrix(e, 1);
        run_random(150);
        drain();

        write_reg(3'd0, 32'h0000_0000);
        stall_mode = 1;
        run_random(200);
        drain();

        write_reg(3'd0, 32'h0000_0001);
        run_random(150);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("quaternion_from_rotation_matrix regression: pass");
        else
            $display("quaternion_from_rotation_matrix regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
